// File: rtl/swdb_pkg.sv
// Package for the switch debounce edge reporter.
// Holds the configuration register layout, register indexes and reset values.
// No dependencies.
package swdb_pkg;

    localparam int DATA_W = 8;
    localparam int CMD_W  = 4;
    localparam int THR_W  = 8;
    localparam int HB_W   = 16;
    localparam int SHIFT_W = 4;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_STABLE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_SHIFT       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_SHIFT        = 2'd3;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET = 8'd3;
    localparam logic [HB_W-1:0]    HEARTBEAT_RESET = 16'd100;
    localparam logic [SHIFT_W-1:0] DATA_SHIFT_RESET = 4'd0;
    localparam logic [SHIFT_W-1:0] CMD_SHIFT_RESET  = 4'd8;

    localparam logic [THR_W-1:0] MATCH_MAX = 8'hFF;
    localparam logic [HB_W-1:0]  TICK_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [THR_W-1:0]   stable_threshold;
        logic [HB_W-1:0]    heartbeat_ticks;
        logic [SHIFT_W-1:0] data_shift;
        logic [SHIFT_W-1:0] cmd_shift;
    } cfg_t;

endpackage

// File: rtl/swdb_debounce.sv
// Debounce stage: candidate word, saturating match count, stable word and
// command-field rising edge detection. Depends on swdb_pkg.
module swdb_debounce
    import swdb_pkg::*;
#(
    parameter int SWITCH_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [SWITCH_BITS-1:0] raw_word,
    input  cfg_t                   cfg,
    output logic [SWITCH_BITS-1:0] stable_next,
    output logic [CMD_W-1:0]       rise_events
);

    logic [SWITCH_BITS-1:0] stable_reg;
    logic [SWITCH_BITS-1:0] cand_reg;
    logic [SWITCH_BITS-1:0] cand_next;
    logic [THR_W-1:0]       count_reg;
    logic [THR_W-1:0]       count_next;
    logic [CMD_W-1:0]       prev_cmd_reg;
    logic [CMD_W-1:0]       prev_cmd_next;
    logic [SWITCH_BITS-1:0] cmd_shifted;
    logic [CMD_W-1:0]       raw_cmd;
    logic                   take_word;

    always_comb
    begin
        cand_next  = cand_reg;
        count_next = count_reg;
        if (raw_word == cand_reg)
        begin
            if (count_reg < cfg.stable_threshold && count_reg < MATCH_MAX)
            begin
                count_next = count_reg + THR_W'(1);
            end
        end
        else
        begin
            cand_next  = raw_word;
            count_next = '0;
        end
    end

    // Bits shifted in from above the word read as zero.
    assign cmd_shifted = raw_word >> cfg.cmd_shift;
    assign raw_cmd     = cmd_shifted[CMD_W-1:0];
    assign take_word   = (count_next >= cfg.stable_threshold) && (raw_word != stable_reg);

    always_comb
    begin
        stable_next   = stable_reg;
        prev_cmd_next = prev_cmd_reg;
        rise_events   = '0;
        if (take_word)
        begin
            stable_next   = raw_word;
            prev_cmd_next = raw_cmd;
            rise_events   = raw_cmd & ~prev_cmd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg   <= '0;
            cand_reg     <= '0;
            count_reg    <= '0;
            prev_cmd_reg <= '0;
        end
        else if (step)
        begin
            stable_reg   <= stable_next;
            cand_reg     <= cand_next;
            count_reg    <= count_next;
            prev_cmd_reg <= prev_cmd_next;
        end
    end

endmodule

// File: rtl/swdb_report.sv
// Report stage: event latch, last reported word, heartbeat tick counter and
// the output register of the result channel. Depends on swdb_pkg.
module swdb_report
    import swdb_pkg::*;
#(
    parameter int SWITCH_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [SWITCH_BITS-1:0] stable_next,
    input  logic [CMD_W-1:0]       rise_events,
    input  cfg_t                   cfg,
    input  logic                   out_stall,
    output logic                   out_free,
    output logic                   out_valid,
    output logic [DATA_W-1:0]      switch_data,
    output logic [CMD_W-1:0]       command_switches,
    output logic [CMD_W-1:0]       rising_events,
    output logic                   is_heartbeat
);

    logic [CMD_W-1:0]       latched_reg;
    logic [CMD_W-1:0]       latched_next;
    logic [SWITCH_BITS-1:0] last_word_reg;
    logic [HB_W-1:0]        ticks_reg;
    logic [HB_W-1:0]        ticks_inc;
    logic                   changed;
    logic                   heartbeat;
    logic                   report;
    logic [SWITCH_BITS-1:0] data_shifted;
    logic [SWITCH_BITS-1:0] cmd_shifted;

    logic                   out_valid_reg;
    logic [DATA_W-1:0]      data_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [CMD_W-1:0]       events_reg;
    logic                   heartbeat_reg;

    assign latched_next = latched_reg | rise_events;
    assign changed      = (stable_next != last_word_reg) || (latched_next != '0);
    assign ticks_inc    = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + HB_W'(1);
    assign heartbeat    = !changed && (ticks_inc >= cfg.heartbeat_ticks);
    assign report       = changed || heartbeat;

    assign data_shifted = stable_next >> cfg.data_shift;
    assign cmd_shifted  = stable_next >> cfg.cmd_shift;

    // The output register frees up in the same cycle its transaction completes.
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg   <= '0;
            last_word_reg <= '1;
            ticks_reg     <= HEARTBEAT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                if (report)
                begin
                    latched_reg   <= '0;
                    last_word_reg <= stable_next;
                    ticks_reg     <= '0;
                end
                else
                begin
                    latched_reg <= latched_next;
                    ticks_reg   <= ticks_inc;
                end
            end
            if (out_free)
            begin
                out_valid_reg <= step && report;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && report)
        begin
            data_reg      <= data_shifted[DATA_W-1:0];
            cmd_reg       <= cmd_shifted[CMD_W-1:0];
            events_reg    <= latched_next;
            heartbeat_reg <= heartbeat;
        end
    end

    assign out_valid        = out_valid_reg;
    assign switch_data      = data_reg;
    assign command_switches = cmd_reg;
    assign rising_events    = events_reg;
    assign is_heartbeat     = heartbeat_reg;

endmodule

// File: rtl/switch_debounce_edge_reporter.sv
// Top level of the switch debounce edge reporter: configuration registers,
// input register and the debounce and report stages.
// Depends on swdb_pkg, swdb_debounce and swdb_report.
//
// Usage:
// Each input transaction on raw_switches (in_valid/in_stall) is one debounce
// tick. A tick gives zero or one report transaction on the output channel
// (out_valid/out_stall) with switch_data, command_switches, rising_events and
// is_heartbeat. The tick is held in an input register, then processed in one
// pass into the output register once it is free. One tick is taken every
// cycle while the receiver does not stall; the single pass through the
// compare and count logic sets that rate. When the receiver stalls with a
// report waiting, the block keeps taking one more tick into its input
// register and then raises in_stall until the report is taken. Reset clears
// the debounce state and the event latch, loads the register defaults, sets
// the last reported word to all ones and leaves the tick counter at the
// heartbeat reset value, so the first tick sends a report. Configuration
// writes are taken in any cycle and land at the next clock edge.
module switch_debounce_edge_reporter
    import swdb_pkg::*;
#(
    parameter int SWITCH_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [15:0]          raw_switches,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DATA_W-1:0]    switch_data,
    output logic [CMD_W-1:0]     command_switches,
    output logic [CMD_W-1:0]     rising_events,
    output logic                 is_heartbeat
);

    localparam int RAW_W = 16;

    cfg_t                   cfg_reg;
    logic                   s1_valid_reg;
    logic [SWITCH_BITS-1:0] raw_reg;
    logic [SWITCH_BITS-1:0] raw_word;
    logic                   out_free;
    logic                   step;
    logic                   in_take;
    logic [SWITCH_BITS-1:0] stable_next;
    logic [CMD_W-1:0]       rise_events;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stable_threshold <= THRESHOLD_RESET;
            cfg_reg.heartbeat_ticks  <= HEARTBEAT_RESET;
            cfg_reg.data_shift       <= DATA_SHIFT_RESET;
            cfg_reg.cmd_shift        <= CMD_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STABLE_THRESHOLD: cfg_reg.stable_threshold <= cfg_wdata[THR_W-1:0];
                REG_HEARTBEAT_TICKS:  cfg_reg.heartbeat_ticks  <= cfg_wdata[HB_W-1:0];
                REG_DATA_SHIFT:       cfg_reg.data_shift       <= cfg_wdata[SHIFT_W-1:0];
                REG_CMD_SHIFT:        cfg_reg.cmd_shift        <= cfg_wdata[SHIFT_W-1:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Raw bits above the switch word are dropped; missing bits read as zero.
    generate
        if (SWITCH_BITS > RAW_W)
        begin : g_wide
            assign raw_word = {{(SWITCH_BITS-RAW_W){1'b0}}, raw_switches};
        end
        else
        begin : g_narrow
            assign raw_word = raw_switches[SWITCH_BITS-1:0];
        end
    endgenerate

    assign step     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            raw_reg <= raw_word;
        end
    end

    swdb_debounce #(
        .SWITCH_BITS (SWITCH_BITS)
    ) u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .raw_word    (raw_reg),
        .cfg         (cfg_reg),
        .stable_next (stable_next),
        .rise_events (rise_events)
    );

    swdb_report #(
        .SWITCH_BITS (SWITCH_BITS)
    ) u_report (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .stable_next      (stable_next),
        .rise_events      (rise_events),
        .cfg              (cfg_reg),
        .out_stall        (out_stall),
        .out_free         (out_free),
        .out_valid        (out_valid),
        .switch_data      (switch_data),
        .command_switches (command_switches),
        .rising_events    (rising_events),
        .is_heartbeat     (is_heartbeat)
    );

endmodule

// File: dv/switch_debounce_edge_reporter_tb.sv
// Self-checking testbench for switch_debounce_edge_reporter: a queue-fed driver,
// a checking monitor and a behavioral predictor of debounce, edge latch and heartbeat.
// Depends on swdb_pkg and the switch_debounce_edge_reporter RTL.
module switch_debounce_edge_reporter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swdb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASE_TICKS = 50;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [CMD_W-1:0]  cmd;
        logic [CMD_W-1:0]  rises;
        logic              heartbeat;
    } report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [15:0]          raw_switches = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [DATA_W-1:0]    switch_data;
    logic [CMD_W-1:0]     command_switches;
    logic [CMD_W-1:0]     rising_events;
    logic                 is_heartbeat;

    // Predicted state of the debouncer and its register copy.
    cfg_t        cfg_shadow = '{THRESHOLD_RESET, HEARTBEAT_RESET, DATA_SHIFT_RESET,
                                CMD_SHIFT_RESET};
    logic [15:0] db_stable = '0;
    logic [15:0] db_candidate = '0;
    logic [7:0]  db_matches = '0;
    logic [3:0]  db_prev_cmd = '0;
    logic [3:0]  db_rises = '0;
    logic [15:0] db_reported = 16'hFFFF;
    logic [15:0] db_quiet = HEARTBEAT_RESET;

    logic [15:0] tick_queue[$];
    report_t     pending_reports[$];
    report_t     oldest;
    int          ticks_queued = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_request = 1'b0;
    bit          steady_flow = 1'b0;

    switch_debounce_edge_reporter DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .raw_switches     (raw_switches),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .switch_data      (switch_data),
        .command_switches (command_switches),
        .rising_events    (rising_events),
        .is_heartbeat     (is_heartbeat)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int draw_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic void emit_expected(input logic heartbeat);
        report_t rep;
        rep.data      = DATA_W'(db_stable >> cfg_shadow.data_shift);
        rep.cmd       = CMD_W'(db_stable >> cfg_shadow.cmd_shift);
        rep.rises     = db_rises;
        rep.heartbeat = heartbeat;
        pending_reports.push_back(rep);
        db_rises    = '0;
        db_reported = db_stable;
        db_quiet    = '0;
    endfunction

    function automatic void debounce_tick(input logic [15:0] raw);
        logic [CMD_W-1:0] cmd;
        if (raw == db_candidate)
        begin
            if (db_matches < cfg_shadow.stable_threshold && db_matches < MATCH_MAX)
                db_matches = db_matches + 8'd1;
        end
        else
        begin
            db_candidate = raw;
            db_matches   = '0;
        end
        if (db_matches >= cfg_shadow.stable_threshold && raw != db_stable)
        begin
            db_stable   = raw;
            cmd         = CMD_W'(db_stable >> cfg_shadow.cmd_shift);
            db_rises    = db_rises | (cmd & ~db_prev_cmd);
            db_prev_cmd = cmd;
        end
        if (db_stable != db_reported || db_rises != '0)
            emit_expected(1'b0);
        else
        begin
            // The quiet counter saturates rather than wrapping.
            if (db_quiet < TICK_MAX)
                db_quiet = db_quiet + 16'd1;
            if (db_quiet >= cfg_shadow.heartbeat_ticks)
                emit_expected(1'b1);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < 50)
            $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Driver: offers queued ticks, predicting each one as its transaction completes.
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            debounce_tick(raw_switches);
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (tick_queue.size() != 0)
            begin
                raw_switches <= tick_queue.pop_front();
                in_valid <= 1'b1;
                gap_left = (steady_flow || $urandom_range(0, 99) < 55) ? 0 : draw_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: checks each report transaction and throttles the output side.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
                report_mismatch($sformatf("unexpected report data=%h cmd=%h rises=%h hb=%b",
                    switch_data, command_switches, rising_events, is_heartbeat));
            else
            begin
                oldest = pending_reports.pop_front();
                if (switch_data !== oldest.data)
                    report_mismatch($sformatf("switch_data %h, expected %h",
                        switch_data, oldest.data));
                if (command_switches !== oldest.cmd)
                    report_mismatch($sformatf("command_switches %h, expected %h",
                        command_switches, oldest.cmd));
                if (rising_events !== oldest.rises)
                    report_mismatch($sformatf("rising_events %h, expected %h",
                        rising_events, oldest.rises));
                if (is_heartbeat !== oldest.heartbeat)
                    report_mismatch($sformatf("is_heartbeat %b, expected %b",
                        is_heartbeat, oldest.heartbeat));
            end
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!steady_flow && $urandom_range(0, 99) < 25)
        begin
            stall_left = draw_len() - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_tick(input logic [15:0] word);
        tick_queue.push_back(word);
        ticks_queued++;
    endtask

    task automatic queue_run(input logic [15:0] word, input int count);
        repeat (count) queue_tick(word);
    endtask

    // One switch change: optional contact bounce, then the new word held long
    // enough to be accepted (or one tick short of it), sometimes a quiet stretch and stray ticks.
    task automatic queue_change(inout logic [15:0] target);
        logic [15:0] next_word;
        int          sel;
        int          hold;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            next_word = target ^ (16'($urandom_range(1, 15)) << cfg_shadow.cmd_shift);
        else if (sel < 70)
            next_word = 16'($urandom);
        else
            next_word = target ^ (16'd1 << $urandom_range(0, 15))
                               ^ (16'd1 << $urandom_range(0, 15));
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 3))
                queue_tick($urandom_range(0, 1) ? 16'($urandom)
                                                : next_word ^ (16'd1 << $urandom_range(0, 15)));
        hold = cfg_shadow.stable_threshold + 1 + $urandom_range(0, 3);
        if (cfg_shadow.stable_threshold > 0 && $urandom_range(0, 99) < 15)
            hold = cfg_shadow.stable_threshold;
        queue_run(next_word, hold);
        target = next_word;
        if (cfg_shadow.heartbeat_ticks <= 40 && $urandom_range(0, 99) < 20)
            queue_run(next_word, cfg_shadow.heartbeat_ticks + 2);
        if ($urandom_range(0, 99) < 10)
            repeat ($urandom_range(1, 4)) queue_tick(16'($urandom));
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || in_valid || pending_reports.size() != 0);
        // A tick with no report may still be inside the block.
        repeat (6) @(negedge clk);
    endtask

    task automatic load_config(input logic [THR_W-1:0] thr, input logic [HB_W-1:0] hb,
                               input logic [SHIFT_W-1:0] dsh, input logic [SHIFT_W-1:0] csh);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_STABLE_THRESHOLD;
        cfg_wdata <= {8'($urandom), thr};
        @(posedge clk);
        cfg_index <= REG_HEARTBEAT_TICKS;
        cfg_wdata <= hb;
        @(posedge clk);
        cfg_index <= REG_DATA_SHIFT;
        cfg_wdata <= {12'($urandom), dsh};
        @(posedge clk);
        cfg_index <= REG_CMD_SHIFT;
        cfg_wdata <= {12'($urandom), csh};
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_shadow = '{thr, hb, dsh, csh};
    endtask

    initial
    begin
        logic [THR_W-1:0]   phase_thr[8] = '{1, 0, 2, 5, 3, 1, 4, 2};
        logic [HB_W-1:0]    phase_hb[8]  = '{0, 1, 20, 65535, 7, 100, 3, 12};
        logic [SHIFT_W-1:0] phase_ds[8]  = '{0, 8, 15, 4, 1, 8, 0, 11};
        logic [SHIFT_W-1:0] phase_cs[8]  = '{12, 0, 15, 8, 3, 13, 8, 6};
        logic [15:0]        plan_word;
        int                 phase_start;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: first tick reports against the all-ones reported word,
        // then full-on, a bounce, and a command nibble that stays high.
        queue_tick(16'h0000);
        queue_run(16'hFFFF, 5);
        queue_run(16'h0F00, 2);
        queue_tick(16'hF0F0);
        queue_run(16'h0F00, 4);
        wait_drained();

        // Zero threshold and zero heartbeat, both fields shifted down by 15 so only the top bit remains.
        load_config(8'd0, 16'd0, 4'd15, 4'd15);
        @(negedge clk);
        queue_run(16'h8000, 2);
        queue_tick(16'h0001);
        queue_tick(16'h8001);
        queue_tick(16'hFFFF);
        queue_tick(16'h0000);
        wait_drained();

        load_config(8'd255, 16'd65535, 4'd8, 4'd12);
        @(negedge clk);
        queue_run(16'h1234, 3);
        wait_drained();

        plan_word = 16'h0000;
        for (int p = 0; p < 8; p++)
        begin
            load_config(phase_thr[p], phase_hb[p], phase_ds[p], phase_cs[p]);
            @(negedge clk);
            steady_flow = (p == 0 || p == 3 || p == 6);
            // With a report on every tick, a long receiver hold-off fills the block.
            if (p == 0)
                hold_request = 1'b1;
            phase_start = ticks_queued;
            while (ticks_queued - phase_start < PHASE_TICKS)
                queue_change(plan_word);
            wait_drained();
        end

        // Maximum threshold: the match count runs up to its limit before the
        // new word is taken, and a few more matching ticks follow.
        load_config(8'd255, 16'd65535, 4'd0, 4'd12);
        @(negedge clk);
        steady_flow = 1'b1;
        plan_word = plan_word ^ 16'h5A5A;
        queue_run(plan_word, 256 + 4);
        wait_drained();

        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/swdb_pkg.sv
rtl/swdb_debounce.sv
rtl/swdb_report.sv
rtl/switch_debounce_edge_reporter.sv
dv/switch_debounce_edge_reporter_tb.sv
